### src/cdas_pkg.sv
// Package for the Gregorian date shifter: field widths, range limits and
// the calendar tables (month lengths, days before a month, leap test).
// No dependencies; used by the top level and by its checker.
package cdas_pkg;

  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int CountW  = 16;
  localparam int DistW   = 18;
  localparam int CycW    = 9;
  localparam int InDataW  = 40;
  localparam int OutDataW = 24;

  typedef logic [YearW-1:0]  year_t;
  typedef logic [MonthW-1:0] month_t;
  typedef logic [DayW-1:0]   day_t;
  typedef logic [CycW-1:0]   cyc_t;

  localparam year_t  YEAR_MAX  = 14'd9999;
  localparam year_t  CYCLE_LEN = 14'd400;
  localparam cyc_t   CYCLE_TOP = 9'd399;
  localparam month_t MONTH_JAN = 4'd1;
  localparam month_t MONTH_FEB = 4'd2;
  localparam month_t MONTH_DEC = 4'd12;
  localparam day_t   DAY_FIRST = 5'd1;
  localparam day_t   DAY_LAST  = 5'd31;

  // Leap test on the year's position within the 400-year cycle.
  function automatic logic is_leap(input cyc_t r);
    logic century;
    century = (r == 9'd100) || (r == 9'd200) || (r == 9'd300);
    return (r[1:0] == 2'b00) && !century;
  endfunction

  function automatic logic [CycW-1:0] days_before_month(input month_t m);
    logic [CycW-1:0] v;
    case (m)
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic day_t month_len(input month_t m, input logic leap);
    day_t v;
    case (m)
      4'd2:                     v = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:  v = 5'd30;
      default:                  v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

### src/calendar_date_add_subtract_days.sv
// Top level of the Gregorian date shifter: stream ports and the sequencer
// that drives one shared day-offset adder. Depends on cdas_pkg.
//
// Usage: a start date, an operation (add or subtract) and a day count come
// in as one transaction on the in_ channel; one transaction with the
// resulting date leaves on the out_ channel. out_tuser flags a result
// outside the years 0000..9999; the date then saturates to 0000-01-01 or
// 9999-12-31.
// Sequence: the start year is reduced modulo 400, the day offset within
// the year is formed, the offset is walked one year at a time and then one
// month at a time, and the output register is loaded. The year and month
// walks both go through the shared adder. One transaction is worked on
// at a time; in_tready is high only while the sequencer is idle.
// The output register holds a finished result while the receiver stalls;
// a new transaction may be taken meanwhile, and its result waits in the
// sequencer until the output register is free.
// Reset (rst_n low, synchronous) returns the sequencer to idle and empties
// the output register.
module calendar_date_add_subtract_days
  import cdas_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // start_year[13:0], start_month[17:14], start_day[22:18], day_count[38:23]
  input  logic [InDataW-1:0]  in_tdata,
  // operation[0]
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // result_year[13:0], result_month[17:14], result_day[22:18]
  output logic [OutDataW-1:0] out_tdata,
  // out_of_range[0]
  output logic                out_tuser
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MOD   = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_YEAR  = 3'd3;
  localparam logic [2:0] S_MONTH = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [1:0] K_OK    = 2'd0;
  localparam logic [1:0] K_UNDER = 2'd1;
  localparam logic [1:0] K_OVER  = 2'd2;

  logic [2:0]              state_r, state_nxt;
  logic [1:0]              kind_r, kind_nxt;
  logic [2:0]              k_r, k_nxt;
  logic                    op_r, op_nxt;
  year_t                   year_r, year_nxt;
  year_t                   rem_r, rem_nxt;
  month_t                  mon_r, mon_nxt;
  day_t                    day_r, day_nxt;
  logic [CountW-1:0]       cnt_r, cnt_nxt;
  logic signed [DistW-1:0] d_r, d_nxt;
  logic                    out_valid_r, out_valid_nxt;
  year_t                   out_year_r, out_year_nxt;
  month_t                  out_mon_r, out_mon_nxt;
  day_t                    out_day_r, out_day_nxt;
  logic                    out_flag_r, out_flag_nxt;

  month_t                  in_mon;
  month_t                  in_mon_c;
  year_t                   sub_val;
  cyc_t                    r_cur, r_prev, r_next;
  logic                    leap_cur, leap_prev;
  logic signed [DistW-1:0] base, add_a, add_b, sum;

  assign in_mon   = in_tdata[17:14];
  assign in_mon_c = (in_mon == 4'd0) ? MONTH_JAN : ((in_mon > MONTH_DEC) ? MONTH_DEC : in_mon);

  assign sub_val   = CYCLE_LEN << k_r;
  assign r_cur     = rem_r[CycW-1:0];
  assign r_prev    = (r_cur == 9'd0) ? CYCLE_TOP : r_cur - 9'd1;
  assign r_next    = (r_cur == CYCLE_TOP) ? 9'd0 : r_cur + 9'd1;
  assign leap_cur  = is_leap(r_cur);
  assign leap_prev = is_leap(r_prev);

  assign base = $signed({{(DistW-CycW){1'b0}}, days_before_month(mon_r)})
              + $signed({{(DistW-1){1'b0}}, (mon_r > MONTH_FEB) && leap_cur})
              + $signed({{(DistW-DayW){1'b0}}, day_r})
              - 18'sd1;

  always_comb begin
    add_a = d_r;
    add_b = '0;
    case (state_r)
      S_INIT: begin
        add_a = base;
        add_b = op_r ? -$signed({2'b00, cnt_r}) : $signed({2'b00, cnt_r});
      end
      S_YEAR: begin
        if (d_r[DistW-1]) begin
          add_b = leap_prev ? 18'sd366 : 18'sd365;
        end else begin
          add_b = leap_cur ? -18'sd366 : -18'sd365;
        end
      end
      S_MONTH: begin
        add_b = -$signed({{(DistW-DayW){1'b0}}, month_len(mon_r, leap_cur)});
      end
      default: begin
        add_b = '0;
      end
    endcase
  end

  assign sum = add_a + add_b;

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    k_nxt         = k_r;
    op_nxt        = op_r;
    year_nxt      = year_r;
    rem_nxt       = rem_r;
    mon_nxt       = mon_r;
    day_nxt       = day_r;
    cnt_nxt       = cnt_r;
    d_nxt         = d_r;
    out_valid_nxt = out_valid_r;
    out_year_nxt  = out_year_r;
    out_mon_nxt   = out_mon_r;
    out_day_nxt   = out_day_r;
    out_flag_nxt  = out_flag_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          year_nxt  = in_tdata[13:0];
          rem_nxt   = in_tdata[13:0];
          mon_nxt   = in_mon_c;
          day_nxt   = in_tdata[22:18];
          cnt_nxt   = in_tdata[38:23];
          k_nxt     = 3'd5;
          kind_nxt  = K_OK;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (rem_r >= sub_val) begin
          rem_nxt = rem_r - sub_val;
        end
        k_nxt = k_r - 3'd1;
        if (k_r == 3'd0) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        d_nxt     = sum;
        state_nxt = S_YEAR;
      end
      S_YEAR: begin
        if (d_r[DistW-1]) begin
          if (year_r == '0) begin
            kind_nxt  = K_UNDER;
            state_nxt = S_DONE;
          end else begin
            year_nxt = year_r - 14'd1;
            rem_nxt  = {{(YearW-CycW){1'b0}}, r_prev};
            d_nxt    = sum;
          end
        end else if (year_r > YEAR_MAX) begin
          kind_nxt  = K_OVER;
          state_nxt = S_DONE;
        end else if (!sum[DistW-1]) begin
          if (year_r == YEAR_MAX) begin
            kind_nxt  = K_OVER;
            state_nxt = S_DONE;
          end else begin
            year_nxt = year_r + 14'd1;
            rem_nxt  = {{(YearW-CycW){1'b0}}, r_next};
            d_nxt    = sum;
          end
        end else begin
          mon_nxt   = MONTH_JAN;
          state_nxt = S_MONTH;
        end
      end
      S_MONTH: begin
        if ((mon_r < MONTH_DEC) && !sum[DistW-1]) begin
          d_nxt   = sum;
          mon_nxt = mon_r + 4'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          case (kind_r)
            K_UNDER: begin
              out_year_nxt = '0;
              out_mon_nxt  = MONTH_JAN;
              out_day_nxt  = DAY_FIRST;
              out_flag_nxt = 1'b1;
            end
            K_OVER: begin
              out_year_nxt = YEAR_MAX;
              out_mon_nxt  = MONTH_DEC;
              out_day_nxt  = DAY_LAST;
              out_flag_nxt = 1'b1;
            end
            default: begin
              out_year_nxt = year_r;
              out_mon_nxt  = mon_r;
              out_day_nxt  = d_r[DayW-1:0] + 5'd1;
              out_flag_nxt = 1'b0;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    k_r        <= k_nxt;
    op_r       <= op_nxt;
    year_r     <= year_nxt;
    rem_r      <= rem_nxt;
    mon_r      <= mon_nxt;
    day_r      <= day_nxt;
    cnt_r      <= cnt_nxt;
    d_r        <= d_nxt;
    out_year_r <= out_year_nxt;
    out_mon_r  <= out_mon_nxt;
    out_day_r  <= out_day_nxt;
    out_flag_r <= out_flag_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_day_r, out_mon_r, out_year_r};
  assign out_tuser  = out_flag_r;

endmodule

### src/cdas_checker.sv
// Port-level checker for the Gregorian date shifter, attached to the top
// level by the bind statement below. Depends on cdas_pkg.
module cdas_checker
  import cdas_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [OutDataW-1:0] out_tdata,
  input logic                out_tuser
);

  // A result that waits for the receiver keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // The block works on one transaction at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // An out-of-range result is one of the two saturated dates.
  a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      ((out_tdata[13:0] == '0) && (out_tdata[17:14] == MONTH_JAN) &&
       (out_tdata[22:18] == DAY_FIRST)) ||
      ((out_tdata[13:0] == YEAR_MAX) && (out_tdata[17:14] == MONTH_DEC) &&
       (out_tdata[22:18] == DAY_LAST)))
    else $error("bad saturated date");

  // An in-range result has a year up to 9999, a month from 1 to 12 and a nonzero day.
  a_valid_date: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      (out_tdata[13:0] <= YEAR_MAX) && (out_tdata[17:14] >= MONTH_JAN) &&
      (out_tdata[17:14] <= MONTH_DEC) && (out_tdata[22:18] != 5'd0))
    else $error("result date out of range");

endmodule

bind calendar_date_add_subtract_days cdas_checker u_cdas_checker (.*);

### tb/sv/tb_date_pkg.sv
`timescale 1ns / 1ps
// Testbench package for the Gregorian date shifter: the operation codes
// shared by the stimulus and the checker. No dependencies.
package tb_date_pkg;

  typedef enum logic {
    OP_ADD = 1'b0,
    OP_SUB = 1'b1
  } shift_op_t;

endpackage

### tb/sv/tb_date_checker.sv
`timescale 1ns / 1ps
// Checker for the Gregorian date shifter: watches both stream channels,
// predicts each shifted date exactly and compares it with the block's result.
// Depends on cdas_pkg and tb_date_pkg.
module tb_date_checker
  import cdas_pkg::*;
  import tb_date_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                in_tuser,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                out_tuser,
  output int                  mismatch_count,
  output int                  dates_pending
);

  typedef struct {
    year_t  year;
    month_t month;
    day_t   day;
    logic   oor;
  } shifted_date_t;

  shifted_date_t due_dates[$];

  initial begin
    mismatch_count = 0;
    dates_pending  = 0;
  end

  function automatic bit leap_year(input longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Day number of January 1st of year y, counted from 0000-01-01.
  function automatic longint year_start(input longint y);
    return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
  endfunction

  function automatic longint days_in_month(input longint y, input int m);
    longint n;
    case (m)
      2:             n = leap_year(y) ? 29 : 28;
      4, 6, 9, 11:   n = 30;
      default:       n = 31;
    endcase
    return n;
  endfunction

  function automatic shifted_date_t shift_date(input shift_op_t op, input year_t y,
                                               input month_t m, input day_t d,
                                               input logic [CountW-1:0] c);
    shifted_date_t r;
    longint yr;
    longint dy;
    longint cnt;
    longint dn;
    int     mo;
    yr  = y;
    dy  = d;
    cnt = c;
    mo  = m;
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    dn = year_start(yr) + dy - 1;
    for (int k = 1; k < mo; k++) begin
      dn += days_in_month(yr, k);
    end
    dn = (op == OP_SUB) ? dn - cnt : dn + cnt;
    if (dn < 0) begin
      r.year = '0;
      r.month = MONTH_JAN;
      r.day = DAY_FIRST;
      r.oor = 1'b1;
    end else if (dn >= year_start(10000)) begin
      r.year = YEAR_MAX;
      r.month = MONTH_DEC;
      r.day = DAY_LAST;
      r.oor = 1'b1;
    end else begin
      yr = (dn * 400) / 146097;
      while (yr > 0 && year_start(yr) > dn) yr--;
      while (year_start(yr + 1) <= dn) yr++;
      dn -= year_start(yr);
      mo = 1;
      while (mo < 12 && dn >= days_in_month(yr, mo)) begin
        dn -= days_in_month(yr, mo);
        mo++;
      end
      r.year = yr[YearW-1:0];
      r.month = month_t'(mo);
      r.day = day_t'(dn + 1);
      r.oor = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    shifted_date_t want;
    year_t  got_year;
    month_t got_month;
    day_t   got_day;
    got_year  = out_tdata[13:0];
    got_month = out_tdata[17:14];
    got_day   = out_tdata[22:18];
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        due_dates.push_back(shift_date(shift_op_t'(in_tuser), in_tdata[13:0],
                                       in_tdata[17:14], in_tdata[22:18],
                                       in_tdata[38:23]));
      end
      if (out_tvalid && out_tready) begin
        if (due_dates.size() == 0) begin
          $error("result transaction with no date expected");
          mismatch_count++;
        end else begin
          want = due_dates.pop_front();
          if (got_year !== want.year) begin
            $error("result_year: expected %0d, got %0d", want.year, got_year);
            mismatch_count++;
          end
          if (got_month !== want.month) begin
            $error("result_month: expected %0d, got %0d", want.month, got_month);
            mismatch_count++;
          end
          if (got_day !== want.day) begin
            $error("result_day: expected %0d, got %0d", want.day, got_day);
            mismatch_count++;
          end
          if (out_tuser !== want.oor) begin
            $error("out_of_range: expected %0d, got %0d", want.oor, out_tuser);
            mismatch_count++;
          end
        end
      end
    end
    dates_pending <= due_dates.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the Gregorian date shifter testbench: clock, reset, directed and
// random date transactions, receiver stalls and the verdict.
// Depends on cdas_pkg, tb_date_pkg, tb_date_checker and the block itself.
module tb_top;
  import cdas_pkg::*;
  import tb_date_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  int                  mismatch_count;
  int                  dates_pending;
  bit                  calm = 1'b0;

  calendar_date_add_subtract_days uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  tb_date_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .mismatch_count (mismatch_count),
    .dates_pending  (dates_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_date(input shift_op_t op, input year_t y, input month_t m,
                            input day_t d, input logic [CountW-1:0] c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, c, d, m, y};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : sink
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  initial begin : stimulus
    shift_op_t           op;
    year_t               y;
    month_t              m;
    day_t                d;
    logic [CountW-1:0]   c;
    int                  pick;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    offer_date(OP_ADD, 14'd2024, 4'd2, 5'd28, 16'd1);
    offer_date(OP_ADD, 14'd1900, 4'd2, 5'd28, 16'd1);
    offer_date(OP_ADD, 14'd2000, 4'd2, 5'd28, 16'd1);
    offer_date(OP_SUB, 14'd2000, 4'd3, 5'd1, 16'd1);
    offer_date(OP_ADD, 14'd2100, 4'd2, 5'd28, 16'd1);
    offer_date(OP_ADD, 14'd0, 4'd1, 5'd1, 16'd0);
    offer_date(OP_SUB, 14'd0, 4'd1, 5'd1, 16'd1);
    offer_date(OP_SUB, 14'd0, 4'd3, 5'd1, 16'd60);
    offer_date(OP_ADD, 14'd9999, 4'd12, 5'd31, 16'd0);
    offer_date(OP_ADD, 14'd9999, 4'd12, 5'd31, 16'd1);
    offer_date(OP_SUB, 14'd9999, 4'd12, 5'd31, 16'd65535);
    offer_date(OP_ADD, 14'd9850, 4'd6, 5'd15, 16'd65535);
    offer_date(OP_ADD, 14'd0, 4'd1, 5'd1, 16'd65535);
    offer_date(OP_SUB, 14'd179, 4'd6, 5'd30, 16'd65535);
    offer_date(OP_ADD, 14'd2023, 4'd0, 5'd15, 16'd10);
    offer_date(OP_ADD, 14'd2023, 4'd13, 5'd5, 16'd3);
    offer_date(OP_SUB, 14'd2023, 4'd15, 5'd31, 16'd0);
    offer_date(OP_ADD, 14'd2023, 4'd3, 5'd0, 16'd0);
    offer_date(OP_ADD, 14'd2023, 4'd2, 5'd31, 16'd0);
    offer_date(OP_ADD, 14'd2024, 4'd4, 5'd31, 16'd0);
    offer_date(OP_SUB, 14'd16383, 4'd12, 5'd31, 16'd0);
    offer_date(OP_SUB, 14'd10100, 4'd1, 5'd1, 16'd65535);
    offer_date(OP_SUB, 14'd10000, 4'd1, 5'd1, 16'd1);
    offer_date(OP_ADD, 14'd1999, 4'd12, 5'd31, 16'd1);
    offer_date(OP_SUB, 14'd2000, 4'd1, 5'd1, 16'd1);

    for (int n = 0; n < 1300; n++) begin
      if (n >= 1100) calm = 1'b1;
      op = shift_op_t'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 80) begin
        // Dates with months 1 to 12 and days 1 to 31, with counts of every size.
        pick = $urandom_range(0, 99);
        if (pick < 70) y = year_t'($urandom_range(0, 9999));
        else if (pick < 85) y = year_t'($urandom_range(0, 400));
        else y = year_t'($urandom_range(9600, 9999));
        m = month_t'($urandom_range(1, 12));
        d = ($urandom_range(0, 4) == 0) ? day_t'($urandom_range(29, 31))
                                        : day_t'($urandom_range(1, 28));
        pick = $urandom_range(0, 99);
        if (pick < 40) c = CountW'($urandom_range(0, 400));
        else if (pick < 70) c = CountW'($urandom_range(0, 4000));
        else c = CountW'($urandom_range(0, 65535));
      end else begin
        y = year_t'($urandom_range(0, 16383));
        m = month_t'($urandom_range(0, 15));
        d = day_t'($urandom_range(0, 31));
        c = CountW'($urandom_range(0, 65535));
      end
      offer_date(op, y, m, d, c);
    end
    in_tvalid <= 1'b0;

    while (dates_pending != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
